// ===== rtl/wgm_pkg.sv =====
// Shared types, command codes and a case-folding helper function for the wildcard glob matcher.
package wgm_pkg;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_VALUE  = 2'd2;
	localparam logic [1:0] CMD_END    = 2'd3;

	localparam logic [15:0] UNIT_QUESTION = 16'h003F;
	localparam logic [15:0] UNIT_STAR     = 16'h002A;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] code_unit;
	} req_t;

	typedef struct packed {
		logic matched;
		logic pattern_overflow;
	} rsp_t;

	// Broadcast from the top level to every cell.
	typedef struct packed {
		logic        rearm;
		logic        step;
		logic        clear;
		logic        write;
		logic        unit_star;
		logic        unit_quest;
		logic [15:0] unit;
	} cell_ctl_t;

	// Handed from one cell to its right-hand neighbor.
	typedef struct packed {
		logic skip;
		logic adv;
		logic vld;
		logic star_v;
	} cell_link_t;

	function automatic logic [15:0] fold_unit(input logic [15:0] u);
		logic [15:0] r;
		r = u;
		if (u >= 16'h0041 && u <= 16'h005A) begin
			r = u + 16'h0020;
		end
		return r;
	endfunction

endpackage

// ===== rtl/wgm_cell.sv =====
// One pattern position of the matcher chain: stored unit, valid bit and active bit.
module wgm_cell #(
	parameter bit FIRST = 1'b0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wgm_pkg::cell_ctl_t    ctl,
	input  wgm_pkg::cell_link_t   lnk_in,
	output wgm_pkg::cell_link_t   lnk_out,
	output logic                  acc
);

	logic        a_q;
	logic        vld_q;
	logic [15:0] unit_q;
	logic        star_q;
	logic        quest_q;

	logic c;
	logic star_v;
	logic match_v;
	logic is_end;
	logic wr;

	// Runs of stars are stored as a single star, so the closure reaches one cell only.
	assign c       = a_q | lnk_in.skip;
	assign star_v  = vld_q & star_q;
	assign match_v = vld_q & ~star_q & (quest_q | (unit_q == ctl.unit));
	assign is_end  = ~vld_q & lnk_in.vld;
	assign wr      = ctl.write & is_end & ~(ctl.unit_star & lnk_in.star_v);
	assign acc     = c & is_end;

	assign lnk_out.skip   = a_q & star_v;
	assign lnk_out.adv    = c & match_v;
	assign lnk_out.vld    = vld_q;
	assign lnk_out.star_v = star_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q   <= FIRST;
			vld_q <= 1'b0;
		end else begin
			if (ctl.rearm) begin
				a_q <= FIRST;
			end else if (ctl.step) begin
				a_q <= (c & star_v) | lnk_in.adv;
			end
			if (ctl.clear) begin
				vld_q <= 1'b0;
			end else if (wr) begin
				vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			unit_q  <= ctl.unit;
			star_q  <= ctl.unit_star;
			quest_q <= ctl.unit_quest;
		end
	end

endmodule

// ===== rtl/wgm_rsp_queue.sv =====
// Four-entry result queue that decouples the matcher from the result consumer.
module wgm_rsp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  wgm_pkg::rsp_t   wr_item,
	input  logic            rd,
	output logic            valid,
	output wgm_pkg::rsp_t   item,
	output logic [2:0]      cnt
);

	wgm_pkg::rsp_t mem [4];
	logic [1:0]    wr_ptr_q;
	logic [1:0]    rd_ptr_q;
	logic [2:0]    cnt_q;
	logic          pop;

	assign valid = cnt_q != 3'd0;
	assign pop   = valid & rd;
	assign item  = mem[rd_ptr_q];
	assign cnt   = cnt_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			cnt_q    <= 3'd0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_q + {2'b0, wr} - {2'b0, pop};
		end
	end

`ifndef NO_ASSERTIONS
	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr && cnt_q == 3'd4 && !pop))
		else $error("result queue written while full");
	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("result queue count out of range");
`endif

endmodule

// ===== rtl/wildcard_glob_matcher_unit.sv =====
// Top level of the case-insensitive wildcard glob matcher built as a chain of cells.
// Throughput: one item per cycle for every command while results are taken; the whole
// active set moves one step per cycle through the row of PATTERN_MAX+1 cells.
// An accepted end-of-value item passes one registered OR-reduction stage and is then
// written to the result queue, which offers it on rsp. req_ready drops only while four
// results wait in that stage and the queue; reset (arst_n low) empties the pattern,
// clears the overflow flag and arms position 0.
module wildcard_glob_matcher_unit #(
	parameter int PATTERN_MAX = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  wgm_pkg::req_t   req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output wgm_pkg::rsp_t   rsp
);

	// One cell per pattern position, including the position after the last unit.
	localparam int NCELL = PATTERN_MAX + 1;
	localparam int LEN_W = $clog2(PATTERN_MAX + 1);
	// Accept bits are reduced in groups of GRP, registered, then ORed once more.
	localparam int GRP   = 32;
	localparam int NGRP  = (NCELL + GRP - 1) / GRP;

	logic                 req_acc;
	logic                 cmd_end;
	logic [LEN_W-1:0]     log_len_q;
	logic                 ovf_q;
	logic                 has_room;
	wgm_pkg::cell_ctl_t   ctl;
	wgm_pkg::cell_link_t  lnk [NCELL+1];
	logic [NCELL-1:0]     acc;
	logic [NGRP*GRP-1:0]  acc_pad;
	logic [NGRP-1:0]      grp_s1;
	logic                 ovf_s1;
	logic                 v_s1;
	wgm_pkg::rsp_t        q_item;
	logic [2:0]           q_cnt;
	logic [2:0]           inflight;

	assign req_acc  = req_valid & req_ready;
	assign cmd_end  = req.cmd == wgm_pkg::CMD_END;
	assign has_room = log_len_q < LEN_W'(PATTERN_MAX);

	// The queue holds at most four results, counting the one in the reduction stage.
	// With a steady consumer one slot drains per cycle, so ends can follow back to back.
	assign inflight  = {2'b0, v_s1} + q_cnt;
	assign req_ready = inflight < 3'd4;

	// Every command except a value unit rearms the active set to position 0.
	// The logical length counts every accepted append up to PATTERN_MAX, so capacity follows the
	// unit count of the pattern as given, even though star runs share one cell.
	assign ctl.rearm      = req_acc & (req.cmd != wgm_pkg::CMD_VALUE);
	assign ctl.step       = req_acc & (req.cmd == wgm_pkg::CMD_VALUE);
	assign ctl.clear      = req_acc & (req.cmd == wgm_pkg::CMD_CLEAR);
	assign ctl.write      = req_acc & (req.cmd == wgm_pkg::CMD_APPEND) & has_room;
	assign ctl.unit_star  = req.code_unit == wgm_pkg::UNIT_STAR;
	assign ctl.unit_quest = req.code_unit == wgm_pkg::UNIT_QUESTION;
	assign ctl.unit       = wgm_pkg::fold_unit(req.code_unit);

	// The left edge of the chain looks like a stored, non-star position.
	assign lnk[0].skip   = 1'b0;
	assign lnk[0].adv    = 1'b0;
	assign lnk[0].vld    = 1'b1;
	assign lnk[0].star_v = 1'b0;

	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		wgm_cell #(
			.FIRST(g == 0)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.lnk_in  (lnk[g]),
			.lnk_out (lnk[g+1]),
			.acc     (acc[g])
		);
	end

	assign acc_pad = (NGRP*GRP)'(acc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_len_q <= '0;
			ovf_q     <= 1'b0;
			v_s1      <= 1'b0;
		end else begin
			v_s1 <= req_acc & cmd_end;
			if (ctl.clear) begin
				log_len_q <= '0;
				ovf_q     <= 1'b0;
			end else if (req_acc && req.cmd == wgm_pkg::CMD_APPEND) begin
				if (has_room) begin
					log_len_q <= log_len_q + LEN_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// First reduction stage: one OR per group of cells, captured at end of value.
	always_ff @(posedge clk) begin
		if (req_acc && cmd_end) begin
			for (int k = 0; k < NGRP; k++) begin
				grp_s1[k] <= |acc_pad[k*GRP +: GRP];
			end
			ovf_s1 <= ovf_q;
		end
	end

	assign q_item.matched          = |grp_s1;
	assign q_item.pattern_overflow = ovf_s1;

	wgm_rsp_queue u_rsp_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (v_s1),
		.wr_item (q_item),
		.rd      (rsp_ready),
		.valid   (rsp_valid),
		.item    (rsp),
		.cnt     (q_cnt)
	);

`ifndef NO_ASSERTIONS
	a_end_starts_result: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && cmd_end) |=> v_s1)
		else $error("end of value did not start a result");
	a_result_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> $past(req_acc && cmd_end))
		else $error("result produced without an end of value");
	a_overflow_on_append: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovf_q) |-> $past(req_acc && req.cmd == wgm_pkg::CMD_APPEND && !has_room))
		else $error("overflow flag set without a dropped append");
	a_stall_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> (v_s1 || rsp_valid))
		else $error("input stalled with no result pending");
	a_tail_never_stored: assert property (@(posedge clk) disable iff (!arst_n)
		!lnk[NCELL].vld)
		else $error("pattern written past capacity");
`endif

endmodule
